@@ rtl/core/pere_pkg.sv @@
// Shared types and constants for the pose error RMS evaluator.
// No dependencies; every other file refers to it by scoped names.
package pere_pkg;

    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_MEAS_OX = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MEAS_OY = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MEAS_OH = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SIM_OX  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SIM_OY  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SIM_OH  = 3'd5;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = 1;
    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 32;

    // Q2.30 reciprocal of the CORDIC gain
    localparam logic signed [33:0] INV_GAIN = 34'sd652032874;
    localparam logic signed [67:0] ROUND_HALF = 68'sd536870912;

    localparam logic signed [33:0] ATAN_TAB [0:31] = '{
        34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
        34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
        34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772,
        34'sd166886, 34'sd83443, 34'sd41722, 34'sd20861,
        34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304,
        34'sd652, 34'sd326, 34'sd163, 34'sd81,
        34'sd41, 34'sd20, 34'sd10, 34'sd5,
        34'sd3, 34'sd1, 34'sd1, 34'sd0
    };

    typedef struct packed {
        logic signed [31:0] meas_x;
        logic signed [31:0] meas_y;
        logic signed [15:0] meas_heading;
        logic signed [31:0] sim_x;
        logic signed [31:0] sim_y;
        logic signed [15:0] sim_heading;
    } t_in;

    typedef struct packed {
        logic signed [31:0] aligned_x;
        logic signed [31:0] aligned_y;
        logic signed [15:0] aligned_heading;
        logic [31:0]        pos_err;
        logic signed [15:0] head_err;
        logic [31:0]        position_rms;
        logic [15:0]        heading_rms;
    } t_out;

    typedef struct packed {
        logic signed [31:0] meas_ox;
        logic signed [31:0] meas_oy;
        logic signed [15:0] meas_oh;
        logic signed [31:0] sim_ox;
        logic signed [31:0] sim_oy;
        logic signed [15:0] sim_oh;
    } t_cfg;

    // Front-end result: offsets from the measured origin and wrapped headings
    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [15:0] ah;
        logic signed [15:0] he;
    } t_work;

endpackage

@@ rtl/core/pere_ifs.sv @@
// Valid/ready channel interfaces for the pose error RMS evaluator.
// Depends on pere_pkg for the payload types.
interface pere_in_if;
    logic           valid;
    logic           ready;
    pere_pkg::t_in  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface pere_out_if;
    logic           valid;
    logic           ready;
    pere_pkg::t_out payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface pere_work_if;
    logic            valid;
    logic            ready;
    pere_pkg::t_work payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface pere_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pere_pkg::REG_IDX_W-1:0] index;
    logic [31:0]                   data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/pere_isqrt.sv @@
// Iterative 64-bit integer square root, one result bit per cycle.
// Depends on pere_pkg for the step count.
module pere_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_value,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_val;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [35:0] n_rem2;
    logic [35:0] n_trial;
    logic [35:0] n_diff;
    logic        n_ge;

    assign n_rem2  = {r_rem, r_val[63:62]};
    assign n_trial = {2'b00, r_root, 2'b01};
    assign n_diff  = n_rem2 - n_trial;
    assign n_ge    = (n_rem2 >= n_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(pere_pkg::SQRT_STEPS);
                r_val  <= i_value;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_val <= {r_val[61:0], 2'b00};
                if (n_ge) begin
                    r_rem  <= n_diff[33:0];
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_rem  <= n_rem2[33:0];
                    r_root <= {r_root[30:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

@@ rtl/core/pere_front.sv @@
// Front end: accept a pose pair, offset it from the measured origin and wrap headings.
// Depends on pere_pkg and the channel interfaces.
module pere_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pere_pkg::t_cfg i_cfg,
    pere_in_if.sink        i_req,
    pere_work_if.source    o_work
);
    logic            r_valid;
    pere_pkg::t_work r_work;
    pere_pkg::t_work n_work;

    always_comb begin
        n_work.dx = {i_req.payload.meas_x[31], i_req.payload.meas_x}
                  - {i_cfg.meas_ox[31], i_cfg.meas_ox};
        n_work.dy = {i_req.payload.meas_y[31], i_req.payload.meas_y}
                  - {i_cfg.meas_oy[31], i_cfg.meas_oy};
        n_work.sx = i_req.payload.sim_x;
        n_work.sy = i_req.payload.sim_y;
        n_work.ah = i_req.payload.meas_heading - i_cfg.meas_oh + i_cfg.sim_oh;
        n_work.he = i_req.payload.sim_heading - n_work.ah;
    end

    assign i_req.ready    = !r_valid || o_work.ready;
    assign o_work.valid   = r_valid;
    assign o_work.payload = r_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                r_valid <= 1'b1;
                r_work  <= n_work;
            end else if (o_work.ready) begin
                r_valid <= 1'b0;
            end
        end
    end
endmodule

@@ rtl/core/pere_fifo.sv @@
// Two-entry queue between the front end and the back end.
// Depends on pere_pkg and the channel interfaces.
module pere_fifo (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pere_work_if.sink   i_work,
    pere_work_if.source o_work
);
    pere_pkg::t_work               r_mem [pere_pkg::FIFO_DEPTH];
    logic [pere_pkg::FIFO_AW-1:0]  r_wp;
    logic [pere_pkg::FIFO_AW-1:0]  r_rp;
    logic [pere_pkg::FIFO_AW:0]    r_cnt;
    logic                          n_push;
    logic                          n_pop;

    assign i_work.ready   = (r_cnt != (pere_pkg::FIFO_AW+1)'(pere_pkg::FIFO_DEPTH));
    assign o_work.valid   = (r_cnt != '0);
    assign o_work.payload = r_mem[r_rp];
    assign n_push = i_work.valid && i_work.ready;
    assign n_pop  = o_work.valid && o_work.ready;

    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_mem[r_wp] <= i_work.payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (n_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (n_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (n_push && !n_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (n_pop && !n_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

@@ rtl/core/pere_back.sv @@
// Back end: CORDIC rotation, error magnitudes, square-sum accumulation and RMS.
// Depends on pere_pkg, the channel interfaces and pere_isqrt.
module pere_back #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pere_pkg::t_cfg i_cfg,
    pere_work_if.sink      i_work,
    pere_out_if.source     o_res
);
    localparam int CW = $clog2(CORDIC_STEPS + 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_CORDIC, ST_ALIGN, ST_PSQRT, ST_ACCUM, ST_DIV, ST_RSQRT, ST_FIN
    } t_state;

    t_state             r_state;
    pere_pkg::t_work    r_work;
    logic [CW-1:0]      r_i;
    logic [3:0]         r_k;
    logic               r_flip;
    logic signed [33:0] r_cx, r_cy, r_cz;
    logic signed [33:0] r_c, r_s;
    logic signed [67:0] r_prod, r_acc;
    logic signed [31:0] r_ax, r_ay;
    logic [31:0]        r_ux, r_uy;
    logic [64:0]        r_sq;
    logic [31:0]        r_pe;
    logic [63:0]        r_psum, r_hsum;
    logic [31:0]        r_count;
    logic [6:0]         r_dcnt;
    logic [63:0]        r_qp, r_qh;
    logic [31:0]        r_rp, r_rh;
    logic [63:0]        r_sa_val;
    logic               r_sa_start, r_sb_start;
    logic [31:0]        r_prms;
    logic [15:0]        r_hrms;
    logic               r_ovalid;
    pere_pkg::t_out     r_out;

    logic signed [33:0] n_ma, n_mb;
    logic [4:0]         n_idx;
    logic signed [15:0] n_th, n_a;
    logic [63:0]        n_hsum;
    logic [32:0]        n_remp, n_remh;
    logic               n_gep, n_geh;
    logic               w_sa_done, w_sb_done;
    logic [31:0]        w_sa_root, w_sb_root;

    function automatic logic signed [31:0] f_align(input logic signed [67:0] acc,
                                                   input logic signed [31:0] org);
        logic signed [38:0] sum;
        sum = $signed({acc[67], acc[67:30]}) + $signed({{7{org[31]}}, org});
        if (sum > 39'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (sum < -39'sd2147483648) begin
            return 32'sh80000000;
        end
        return sum[31:0];
    endfunction

    function automatic logic [31:0] f_abs_err(input logic signed [31:0] s,
                                              input logic signed [31:0] a);
        logic signed [32:0] e;
        logic signed [32:0] ne;
        e  = {s[31], s} - {a[31], a};
        ne = -e;
        return e[32] ? ne[31:0] : e[31:0];
    endfunction

    function automatic logic [63:0] f_satadd(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    pere_isqrt u_sqrt_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sa_start),
        .i_value (r_sa_val),
        .o_done  (w_sa_done),
        .o_root  (w_sa_root)
    );

    pere_isqrt u_sqrt_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sb_start),
        .i_value (r_qh),
        .o_done  (w_sb_done),
        .o_root  (w_sb_root)
    );

    assign n_idx = 5'(r_i);
    assign n_th  = i_cfg.sim_oh - i_cfg.meas_oh;
    assign n_a   = (n_th[15] ^ n_th[14]) ? {~n_th[15], n_th[14:0]} : n_th;

    // Shared multiplier operand select
    always_comb begin
        n_ma = '0;
        n_mb = '0;
        if (r_state == ST_ALIGN) begin
            case (r_k)
                4'd0: begin n_ma = r_c; n_mb = {r_work.dx[32], r_work.dx}; end
                4'd1: begin n_ma = r_s; n_mb = {r_work.dy[32], r_work.dy}; end
                4'd2: begin n_ma = r_s; n_mb = {r_work.dx[32], r_work.dx}; end
                4'd3: begin n_ma = r_c; n_mb = {r_work.dy[32], r_work.dy}; end
                4'd6: begin n_ma = {2'b00, r_ux}; n_mb = {2'b00, r_ux}; end
                4'd7: begin n_ma = {2'b00, r_uy}; n_mb = {2'b00, r_uy}; end
                default: begin n_ma = '0; n_mb = '0; end
            endcase
        end else if (r_state == ST_ACCUM) begin
            case (r_k)
                4'd0: begin n_ma = {2'b00, r_pe}; n_mb = {2'b00, r_pe}; end
                4'd1: begin
                    n_ma = {{18{r_work.he[15]}}, r_work.he};
                    n_mb = {{18{r_work.he[15]}}, r_work.he};
                end
                default: begin n_ma = '0; n_mb = '0; end
            endcase
        end
    end

    assign n_hsum = f_satadd(r_hsum, r_prod[63:0]);
    assign n_remp = {r_rp, r_qp[63]};
    assign n_remh = {r_rh, r_qh[63]};
    assign n_gep  = (n_remp >= {1'b0, r_count});
    assign n_geh  = (n_remh >= {1'b0, r_count});

    assign i_work.ready  = (r_state == ST_IDLE);
    assign o_res.valid   = r_ovalid;
    assign o_res.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_psum     <= '0;
            r_hsum     <= '0;
            r_count    <= '0;
            r_ovalid   <= 1'b0;
            r_sa_start <= 1'b0;
            r_sb_start <= 1'b0;
        end else begin
            r_prod     <= n_ma * n_mb;
            r_sa_start <= 1'b0;
            r_sb_start <= 1'b0;
            if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_work.valid) begin
                        r_work  <= i_work.payload;
                        r_i     <= '0;
                        r_flip  <= n_th[15] ^ n_th[14];
                        r_cx    <= pere_pkg::INV_GAIN;
                        r_cy    <= '0;
                        r_cz    <= {{2{n_a[15]}}, n_a, 16'h0000};
                        r_state <= ST_CORDIC;
                    end
                end
                ST_CORDIC: begin
                    if (r_i == CW'(CORDIC_STEPS)) begin
                        r_c     <= r_flip ? -r_cx : r_cx;
                        r_s     <= r_flip ? -r_cy : r_cy;
                        r_k     <= '0;
                        r_state <= ST_ALIGN;
                    end else begin
                        if (!r_cz[33]) begin
                            r_cx <= r_cx - (r_cy >>> n_idx);
                            r_cy <= r_cy + (r_cx >>> n_idx);
                            r_cz <= r_cz - pere_pkg::ATAN_TAB[n_idx];
                        end else begin
                            r_cx <= r_cx + (r_cy >>> n_idx);
                            r_cy <= r_cy - (r_cx >>> n_idx);
                            r_cz <= r_cz + pere_pkg::ATAN_TAB[n_idx];
                        end
                        r_i <= r_i + 1'b1;
                    end
                end
                ST_ALIGN: begin
                    r_k <= r_k + 4'd1;
                    case (r_k)
                        4'd1: r_acc <= r_prod;
                        4'd2: r_acc <= r_acc - r_prod + pere_pkg::ROUND_HALF;
                        4'd3: begin
                            r_ax  <= f_align(r_acc, i_cfg.sim_ox);
                            r_acc <= r_prod;
                        end
                        4'd4: begin
                            r_acc <= r_acc + r_prod + pere_pkg::ROUND_HALF;
                            r_ux  <= f_abs_err(r_work.sx, r_ax);
                        end
                        4'd5: r_ay <= f_align(r_acc, i_cfg.sim_oy);
                        4'd6: r_uy <= f_abs_err(r_work.sy, r_ay);
                        4'd7: r_sq <= {1'b0, r_prod[63:0]};
                        4'd8: r_sq <= r_sq + {1'b0, r_prod[63:0]};
                        4'd9: begin
                            r_k <= '0;
                            if (r_sq[64]) begin
                                r_pe    <= '1;
                                r_state <= ST_ACCUM;
                            end else begin
                                r_sa_val   <= r_sq[63:0];
                                r_sa_start <= 1'b1;
                                r_state    <= ST_PSQRT;
                            end
                        end
                        default: ;
                    endcase
                end
                ST_PSQRT: begin
                    if (w_sa_done) begin
                        r_pe    <= w_sa_root;
                        r_k     <= '0;
                        r_state <= ST_ACCUM;
                    end
                end
                ST_ACCUM: begin
                    r_k <= r_k + 4'd1;
                    case (r_k)
                        4'd1: r_psum <= f_satadd(r_psum, r_prod[63:0]);
                        4'd2: begin
                            r_hsum <= n_hsum;
                            if (r_count != '1) begin
                                r_count <= r_count + 32'd1;
                            end
                            r_qp    <= r_psum;
                            r_qh    <= n_hsum;
                            r_rp    <= '0;
                            r_rh    <= '0;
                            r_dcnt  <= 7'(pere_pkg::DIV_STEPS);
                            r_state <= ST_DIV;
                        end
                        default: ;
                    endcase
                end
                ST_DIV: begin
                    if (r_dcnt != '0) begin
                        r_rp   <= n_gep ? 32'(n_remp - {1'b0, r_count}) : n_remp[31:0];
                        r_rh   <= n_geh ? 32'(n_remh - {1'b0, r_count}) : n_remh[31:0];
                        r_qp   <= {r_qp[62:0], n_gep};
                        r_qh   <= {r_qh[62:0], n_geh};
                        r_dcnt <= r_dcnt - 7'd1;
                    end else begin
                        r_sa_val   <= r_qp;
                        r_sa_start <= 1'b1;
                        r_sb_start <= 1'b1;
                        r_state    <= ST_RSQRT;
                    end
                end
                ST_RSQRT: begin
                    if (w_sa_done && w_sb_done) begin
                        r_prms  <= w_sa_root;
                        r_hrms  <= (w_sb_root > 32'd32768) ? 16'h8000 : w_sb_root[15:0];
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!r_ovalid || o_res.ready) begin
                        r_out.aligned_x       <= r_ax;
                        r_out.aligned_y       <= r_ay;
                        r_out.aligned_heading <= r_work.ah;
                        r_out.pos_err         <= r_pe;
                        r_out.head_err        <= r_work.he;
                        r_out.position_rms    <= r_prms;
                        r_out.heading_rms     <= r_hrms;
                        r_ovalid              <= 1'b1;
                        r_state               <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

@@ rtl/core/pose_error_rmse_evaluator_core.sv @@
// Top level of the pose error RMS evaluator: configuration registers and the
// front end, queue and back end. Depends on pere_pkg, pere_ifs and all pere_* modules.
//
// Usage:
//   i_req carries one request: a measured and a simulated pose. o_res returns one
//   result per request: the measured pose aligned into the simulated frame, the
//   position and heading errors, and the running RMS of both since reset.
//   i_cfg writes the six origin registers (index 0..5); other indexes are dropped.
//   Write them only while no request is in flight.
// Structure: the front end registers a request and a two-entry queue holds it
//   for the back end. Each back-end pass runs the CORDIC iterations, a rotation
//   sequence on one shared 34x34 multiplier, a square root, a restoring division
//   and a second square root. Throughput is one request per back-end pass; the
//   front end and the queue absorb up to three requests while the back end works.
// Reset: synchronous, active low; clears the origins, the square sums and the
//   sample count, and empties the queue and the output register.
// Stall: a finished result is held in the output register until taken; the back
//   end waits for it to drain, and the queue and front end keep accepting.
module pose_error_rmse_evaluator_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pere_in_if.sink    i_req,
    pere_out_if.source o_res,
    pere_cfg_if.sink   i_cfg
);
    pere_pkg::t_cfg r_cfg;

    pere_work_if w_front ();
    pere_work_if w_back ();

    // Configuration writes are always accepted
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                pere_pkg::REG_MEAS_OX: r_cfg.meas_ox <= i_cfg.data;
                pere_pkg::REG_MEAS_OY: r_cfg.meas_oy <= i_cfg.data;
                pere_pkg::REG_MEAS_OH: r_cfg.meas_oh <= i_cfg.data[15:0];
                pere_pkg::REG_SIM_OX:  r_cfg.sim_ox  <= i_cfg.data;
                pere_pkg::REG_SIM_OY:  r_cfg.sim_oy  <= i_cfg.data;
                pere_pkg::REG_SIM_OH:  r_cfg.sim_oh  <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    // Offset from the measured origin and wrap the headings
    pere_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_req   (i_req),
        .o_work  (w_front)
    );

    // Decouple the front end from the long back-end pass
    pere_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_work  (w_front),
        .o_work  (w_back)
    );

    // Rotate, measure the errors and update the running RMS
    pere_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_work  (w_back),
        .o_res   (o_res)
    );
endmodule

@@ bench/pose_error_rmse_evaluator_core_tb.sv @@
// Self-checking bench for pose_error_rmse_evaluator_core: predicts every result from
// its own pose alignment and RMS model and compares each field of every response.
// Depends on pere_pkg, pere_ifs and the RTL of the evaluator.
module pose_error_rmse_evaluator_core_tb;

    localparam int STEPS = 16;
    localparam int DRAIN_CYCLES = 300;
    // indexes past the last origin register; the block must drop these writes
    localparam logic [pere_pkg::REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [pere_pkg::REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic i_clk;
    logic i_rst_n;

    pere_in_if  req_if ();
    pere_out_if res_if ();
    pere_cfg_if cfg_if ();

    pose_error_rmse_evaluator_core #(.CORDIC_STEPS(STEPS)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // origin registers and accumulators as the block should hold them
    pere_pkg::t_cfg origin;
    logic [63:0]    pos_sq_sum;
    logic [63:0]    head_sq_sum;
    logic [31:0]    n_samples;

    pere_pkg::t_out expected_poses[$];
    int             mismatches;
    bit             quiet;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Floor square root by trial bits; the root of a 64-bit value fits 32 bits.
    function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
        logic [31:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = {32'd0, root | (32'd1 << b)};
            if (trial * trial <= v) root = trial[31:0];
        end
        return root;
    endfunction

    // Rotation-mode CORDIC on a binary angle; cos and sin come back in Q2.30.
    function automatic void cordic_sincos(input logic signed [15:0] ang,
                                          output longint c, output longint s);
        longint a, x, y, z, sx, sy;
        bit flip;
        a = ang;
        flip = 1'b0;
        // fold the back half-turn onto the front and negate at the end
        if (a >= 16384 || a < -16384) begin
            a = (a >= 0) ? a - 32768 : a + 32768;
            flip = 1'b1;
        end
        x = pere_pkg::INV_GAIN;
        y = 0;
        z = a * 65536;
        for (int i = 0; i < STEPS && i < 32; i++) begin
            sx = y >>> i;
            sy = x >>> i;
            if (z >= 0) begin
                x = x - sx; y = y + sy; z = z - longint'(pere_pkg::ATAN_TAB[i]);
            end else begin
                x = x + sx; y = y - sy; z = z + longint'(pere_pkg::ATAN_TAB[i]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic logic signed [31:0] clamp_q16(input logic signed [127:0] v);
        if (v > 128'sd2147483647) return 32'sh7fffffff;
        if (v < -128'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Align one pose pair, derive both errors and advance the running sums.
    function automatic pere_pkg::t_out align_and_score(input pere_pkg::t_in p);
        pere_pkg::t_out r;
        longint c, s;
        logic signed [127:0] wc, ws, dx, dy, rx, ry, ex, ey, ux, uy, sq;
        logic [64:0] acc;
        logic [31:0] pe;
        logic [31:0] hr;
        cordic_sincos(origin.sim_oh - origin.meas_oh, c, s);
        wc = c;
        ws = s;
        dx = p.meas_x;
        dx = dx - origin.meas_ox;
        dy = p.meas_y;
        dy = dy - origin.meas_oy;
        rx = (wc * dx - ws * dy + 128'sd536870912) >>> 30;
        ry = (ws * dx + wc * dy + 128'sd536870912) >>> 30;
        r.aligned_x = clamp_q16(rx + origin.sim_ox);
        r.aligned_y = clamp_q16(ry + origin.sim_oy);
        r.aligned_heading = p.meas_heading - origin.meas_oh + origin.sim_oh;
        r.head_err = p.sim_heading - r.aligned_heading;

        ex = p.sim_x;
        ex = ex - r.aligned_x;
        ey = p.sim_y;
        ey = ey - r.aligned_y;
        ux = (ex < 0) ? -ex : ex;
        uy = (ey < 0) ? -ey : ey;
        sq = ux * ux + uy * uy;
        pe = (sq >= (128'sd1 <<< 64)) ? 32'hffffffff : floor_sqrt(sq[63:0]);
        r.pos_err = pe;

        acc = {1'b0, pos_sq_sum} + {33'd0, pe} * {33'd0, pe};
        pos_sq_sum = acc[64] ? 64'hffffffffffffffff : acc[63:0];
        acc = {1'b0, head_sq_sum}
            + 65'(longint'(r.head_err) * longint'(r.head_err));
        head_sq_sum = acc[64] ? 64'hffffffffffffffff : acc[63:0];
        if (n_samples != 32'hffffffff) n_samples = n_samples + 1;

        r.position_rms = floor_sqrt(pos_sq_sum / {32'd0, n_samples});
        hr = floor_sqrt(head_sq_sum / {32'd0, n_samples});
        if (hr > 32'd32768) hr = 32'd32768;
        r.heading_rms = hr[15:0];
        return r;
    endfunction

    // Response side: random back-pressure, quiet stretches hold ready high.
    always @(posedge i_clk) begin
        res_if.ready <= quiet || ($urandom_range(99) >= 22);
    end

    always @(posedge i_clk) begin
        pere_pkg::t_out want, got;
        logic [31:0] w_f[7];
        logic [31:0] g_f[7];
        string names[7];
        if (i_rst_n && res_if.valid === 1'b1 && res_if.ready) begin
            got = res_if.payload;
            if (expected_poses.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected response %p", got);
            end else begin
                want = expected_poses.pop_front();
                names = '{"aligned_x", "aligned_y", "aligned_heading", "pos_err",
                          "head_err", "position_rms", "heading_rms"};
                w_f = '{want.aligned_x, want.aligned_y, 32'(want.aligned_heading),
                        want.pos_err, 32'(want.head_err), want.position_rms,
                        32'(want.heading_rms)};
                g_f = '{got.aligned_x, got.aligned_y, 32'(got.aligned_heading),
                        got.pos_err, 32'(got.head_err), got.position_rms,
                        32'(got.heading_rms)};
                for (int f = 0; f < 7; f++) begin
                    if (g_f[f] !== w_f[f]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%s: expected %h, got %h", names[f], w_f[f], g_f[f]);
                    end
                end
            end
        end
    end

    // Send one request, idling first at random. Valid stays high after
    // acceptance so back-to-back requests need no second assignment in one step.
    task automatic send_pose(input pere_pkg::t_in p);
        if (!quiet && $urandom_range(99) < 22) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.payload <= p;
        do @(posedge i_clk); while (!req_if.ready);
        expected_poses.push_back(align_and_score(p));
    endtask

    // Drop valid and hold until every response is back, plus the back-end pass.
    task automatic drain_requests();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_poses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_origin(input logic [pere_pkg::REG_IDX_W-1:0] idx,
                                input logic [31:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            pere_pkg::REG_MEAS_OX: origin.meas_ox = data;
            pere_pkg::REG_MEAS_OY: origin.meas_oy = data;
            pere_pkg::REG_MEAS_OH: origin.meas_oh = data[15:0];
            pere_pkg::REG_SIM_OX:  origin.sim_ox = data;
            pere_pkg::REG_SIM_OY:  origin.sim_oy = data;
            pere_pkg::REG_SIM_OH:  origin.sim_oh = data[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_origins(input logic [31:0] mox, moy, input logic [15:0] moh,
                               input logic [31:0] sox, soy, input logic [15:0] soh);
        write_origin(pere_pkg::REG_MEAS_OX, mox);
        write_origin(pere_pkg::REG_MEAS_OY, moy);
        write_origin(pere_pkg::REG_MEAS_OH, {16'd0, moh});
        write_origin(pere_pkg::REG_SIM_OX, sox);
        write_origin(pere_pkg::REG_SIM_OY, soy);
        write_origin(pere_pkg::REG_SIM_OH, {16'd0, soh});
    endtask

    // Positions within a few tens of metres keep the square sums far from
    // saturation; the wide form spans every bit of the field.
    function automatic logic [31:0] rand_q16(input bit wide);
        return wide ? $urandom : 32'($signed($urandom) >>> 11);
    endfunction

    function automatic pere_pkg::t_in rand_pose(input bit wide);
        pere_pkg::t_in p;
        p.meas_x = rand_q16(wide);
        p.meas_y = rand_q16(wide);
        p.meas_heading = 16'($urandom);
        // most samples track the measurement closely, as a real run would
        if (!wide && $urandom_range(3) != 0) begin
            p.sim_x = p.meas_x + 32'($signed($urandom) >>> 18);
            p.sim_y = p.meas_y + 32'($signed($urandom) >>> 18);
        end else begin
            p.sim_x = rand_q16(wide);
            p.sim_y = rand_q16(wide);
        end
        p.sim_heading = 16'($urandom);
        return p;
    endfunction

    function automatic pere_pkg::t_in make_pose(input logic [31:0] mx, my,
                                                input logic [15:0] mh,
                                                input logic [31:0] sx, sy,
                                                input logic [15:0] sh);
        pere_pkg::t_in p;
        p.meas_x = mx; p.meas_y = my; p.meas_heading = mh;
        p.sim_x = sx; p.sim_y = sy; p.sim_heading = sh;
        return p;
    endfunction

    // Zero origins: identity alignment, heading wrap around pi.
    task automatic test_identity_frame();
        send_pose(make_pose(0, 0, 0, 0, 0, 0));
        send_pose(make_pose(32'h00010000, 32'h00020000, 16'd100,
                            32'h00040000, 32'h00060000, 16'd50));
        send_pose(make_pose(0, 0, 16'h8000, 0, 0, 16'h7fff));
        send_pose(make_pose(0, 0, 16'h7fff, 0, 0, 16'h8000));
        send_pose(make_pose(0, 0, 16'hc000, 0, 0, 16'h4000));
        send_pose(make_pose(32'hfff00000, 32'h00100000, 16'h4000,
                            32'h00100000, 32'hfff00000, 16'hc000));
    endtask

    // Origin headings on the quadrant boundaries of the CORDIC fold.
    task automatic test_rotation_quadrants();
        logic [15:0] angles[6];
        angles = '{16'h4000, 16'hbfff, 16'hc000, 16'h3fff, 16'h8000, 16'h7fff};
        foreach (angles[k]) begin
            drain_requests();
            set_origins(32'h00010000, 32'hffff0000, 16'd0,
                        32'h00030000, 32'h00020000, angles[k]);
            send_pose(make_pose(32'h00050000, 32'h00020000, 16'd1234,
                                32'h00010000, 32'h00020000, 16'hfedc));
            send_pose(rand_pose(1'b0));
        end
    endtask

    // Random origins per phase; a quiet stretch with no idling on either side.
    task automatic test_random_tracks(input int items, input bit wide);
        for (int n = 0; n < items; n++) begin
            if (n % 40 == 0) begin
                drain_requests();
                set_origins(rand_q16(wide), rand_q16(wide), 16'($urandom),
                            rand_q16(wide), rand_q16(wide), 16'($urandom));
                if ($urandom_range(1)) write_origin(REG_SPARE_LO, $urandom);
                else write_origin(REG_SPARE_HI, $urandom);
            end
            quiet = (!wide && n >= 120 && n < 200);
            send_pose(rand_pose(wide));
        end
        quiet = 1'b0;
    endtask

    // Extreme origins: aligned positions clip to int32, errors saturate and the
    // square sums pin at their ceiling for the rest of the run.
    task automatic test_saturation();
        drain_requests();
        set_origins(32'h80000000, 32'h80000000, 16'h8000,
                    32'h7fffffff, 32'h7fffffff, 16'h7fff);
        send_pose(make_pose(32'h7fffffff, 32'h7fffffff, 16'h7fff,
                            32'h80000000, 32'h80000000, 16'h8000));
        send_pose(make_pose(32'h7fffffff, 32'h80000000, 16'h8000,
                            32'h80000000, 32'h7fffffff, 16'h7fff));
        drain_requests();
        set_origins(32'h7fffffff, 32'h7fffffff, 16'h7fff,
                    32'h80000000, 32'h80000000, 16'h8000);
        send_pose(make_pose(32'h80000000, 32'h80000000, 16'h8000,
                            32'h7fffffff, 32'h7fffffff, 16'h0000));
        send_pose(make_pose(0, 0, 0, 32'h7fffffff, 32'h80000000, 16'h8000));
    endtask

    initial begin
        mismatches = 0;
        quiet = 1'b0;
        origin = '0;
        pos_sq_sum = '0;
        head_sq_sum = '0;
        n_samples = '0;
        i_rst_n <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.payload <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= '0;
        cfg_if.data <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_identity_frame();
        test_rotation_quadrants();
        test_random_tracks(300, 1'b0);
        test_random_tracks(100, 1'b1);
        test_saturation();
        drain_requests();

        if (mismatches == 0 && expected_poses.size() == 0)
            $display("pose_error_rmse_evaluator_core_tb: PASS");
        else
            $display("pose_error_rmse_evaluator_core_tb: FAIL");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #(20 * 4_000_000);
        $display("pose_error_rmse_evaluator_core_tb: FAIL");
        $finish;
    end
endmodule
